/* design/cascaded_key_compactor_macros.svh */
// ----------------------------------------------------------------------------
// cascaded key compactor assertion macros
// Shared property wrappers for the compactor checks, clocked on clk_i and
// disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef CASCADED_KEY_COMPACTOR_MACROS_SVH
`define CASCADED_KEY_COMPACTOR_MACROS_SVH

// same-cycle implication
`define CKC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CKC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/ckc_pkg.sv */
// ----------------------------------------------------------------------------
// ckc_pkg
// Widths, derived sizes and the controller/datapath interface types of the
// cascaded key compactor.
// ----------------------------------------------------------------------------
package ckc_pkg;

  localparam int unsigned TRICK_KEY_BITS = 12;
  localparam int unsigned RANK_KEY_BITS  = 16;
  localparam int unsigned CASE_KEY_BITS  = 8;
  localparam int unsigned TRICK_ID_BITS  = 8;
  localparam int unsigned RANK_ID_BITS   = 10;
  localparam int unsigned CASE_ID_BITS   = 7;
  localparam int unsigned RC_ID_BITS     = 12;
  localparam int unsigned RC_KEY_BITS    = RANK_ID_BITS + CASE_ID_BITS;
  localparam int unsigned COMPACT_BITS   = 20;
  localparam int unsigned CAT_BITS       = RC_ID_BITS + TRICK_ID_BITS;

  localparam int unsigned SWEEP_TR = (TRICK_KEY_BITS > RANK_KEY_BITS) ?
                                     TRICK_KEY_BITS : RANK_KEY_BITS;
  localparam int unsigned SWEEP_CR = (CASE_KEY_BITS > RC_KEY_BITS) ?
                                     CASE_KEY_BITS : RC_KEY_BITS;
  localparam int unsigned SWEEP_BITS = (SWEEP_TR > SWEEP_CR) ? SWEEP_TR : SWEEP_CR;

  typedef struct packed {
    logic sweep;
    logic accept;
    logic look;
    logic commit;
  } ckc_cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic out_free;
  } ckc_status_t;

endpackage

/* design/ckc_ram.sv */
// ----------------------------------------------------------------------------
// ckc_ram
// Simple dual-port synchronous RAM, one write port and one registered read
// port with read enable.
// ----------------------------------------------------------------------------
module ckc_ram #(
  parameter int unsigned AddrBits = 8,
  parameter int unsigned DataBits = 8
) (
  input  logic                clk_i,
  input  logic                rd_en_i,
  input  logic [AddrBits-1:0] rd_addr_i,
  output logic [DataBits-1:0] rd_data_o,
  input  logic                wr_en_i,
  input  logic [AddrBits-1:0] wr_addr_i,
  input  logic [DataBits-1:0] wr_data_i
);

  logic [DataBits-1:0] mem_q [2**AddrBits];
  logic [DataBits-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* design/ckc_ctrl.sv */
// ----------------------------------------------------------------------------
// ckc_ctrl
// Sequencer of the compactor: table clearing pass after reset, then for each
// transaction a first lookup, the dependent rankcase lookup and the commit.
// ----------------------------------------------------------------------------
module ckc_ctrl import ckc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  ckc_status_t status_i,
  output ckc_cmd_t    cmd_o
);

  localparam logic [1:0] StSweep = 2'd0;
  localparam logic [1:0] StIdle  = 2'd1;
  localparam logic [1:0] StLook  = 2'd2;
  localparam logic [1:0] StPair  = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StSweep: begin
        cmd_o.sweep = 1'b1;
        if (status_i.sweep_last) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = StLook;
        end
      end
      StLook: begin
        cmd_o.look = 1'b1;
        state_d    = StPair;
      end
      StPair: begin
        if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = StIdle;
        end
      end
      default: state_d = StSweep;
    endcase
  end

  assign in_ready_o = (state_q == StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StSweep;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* design/ckc_datapath.sv */
// ----------------------------------------------------------------------------
// ckc_datapath
// Four id tables with their counters, the id lookup logic, the clearing
// sweep counter and the output register.
// ----------------------------------------------------------------------------
module ckc_datapath import ckc_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ckc_cmd_t                  cmd_i,
  output ckc_status_t               status_o,
  input  logic [TRICK_KEY_BITS-1:0] trick_key_i,
  input  logic [RANK_KEY_BITS-1:0]  rank_key_i,
  input  logic [CASE_KEY_BITS-1:0]  case_key_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [COMPACT_BITS-1:0]   compact_key_o,
  output logic                      overflow_o
);

  // clearing sweep
  logic [SWEEP_BITS-1:0] sweep_cnt_q, sweep_cnt_d;

  // latched keys
  logic [TRICK_KEY_BITS-1:0] tk_q;
  logic [RANK_KEY_BITS-1:0]  rk_q;
  logic [CASE_KEY_BITS-1:0]  ck_q;

  // counters hold up to their capacity
  logic [TRICK_ID_BITS:0] next_t_q, next_t_d;
  logic [RANK_ID_BITS:0]  next_r_q, next_r_d;
  logic [CASE_ID_BITS:0]  next_c_q, next_c_d;
  logic [RC_ID_BITS:0]    next_rc_q, next_rc_d;

  // table read data
  logic [TRICK_ID_BITS:0] t_rd;
  logic [RANK_ID_BITS:0]  r_rd;
  logic [CASE_ID_BITS:0]  c_rd;
  logic [RC_ID_BITS:0]    rc_rd;

  // first lookup
  logic                   t_seen, r_seen, c_seen;
  logic [TRICK_ID_BITS:0] t_dec;
  logic [RANK_ID_BITS:0]  r_dec;
  logic [CASE_ID_BITS:0]  c_dec;
  logic [TRICK_ID_BITS-1:0] t_id;
  logic [RANK_ID_BITS-1:0]  r_id;
  logic [CASE_ID_BITS-1:0]  c_id;
  logic                     first_ok;
  logic [RC_KEY_BITS-1:0]   rck;

  logic [TRICK_ID_BITS-1:0] tid_q;
  logic [RANK_ID_BITS-1:0]  rid_q;
  logic [CASE_ID_BITS-1:0]  cid_q;
  logic                     tnew_q, rnew_q, cnew_q, ok1_q;
  logic [RC_KEY_BITS-1:0]   rck_q;

  // rankcase lookup
  logic                  rc_seen, rc_ok, ok_all;
  logic [RC_ID_BITS:0]   rc_dec;
  logic [RC_ID_BITS-1:0] rc_id;
  logic [CAT_BITS-1:0]   cat;

  // table writes
  logic                      t_we, r_we, c_we, rc_we;
  logic                      t_inc, r_inc, c_inc, rc_inc;
  logic [TRICK_KEY_BITS-1:0] t_wa;
  logic [RANK_KEY_BITS-1:0]  r_wa;
  logic [CASE_KEY_BITS-1:0]  c_wa;
  logic [RC_KEY_BITS-1:0]    rc_wa;
  logic [TRICK_ID_BITS:0]    t_wd;
  logic [RANK_ID_BITS:0]     r_wd;
  logic [CASE_ID_BITS:0]     c_wd;
  logic [RC_ID_BITS:0]       rc_wd;

  // output register
  logic                    out_valid_q;
  logic [COMPACT_BITS-1:0] compact_q;
  logic                    overflow_q;

  assign sweep_cnt_d         = sweep_cnt_q + {{(SWEEP_BITS-1){1'b0}}, 1'b1};
  assign status_o.sweep_last = &sweep_cnt_q;
  assign status_o.out_free   = ~out_valid_q | out_ready_i;

  // first lookup on the three raw keys
  assign t_seen = |t_rd;
  assign r_seen = |r_rd;
  assign c_seen = |c_rd;
  assign t_dec  = t_rd - {{TRICK_ID_BITS{1'b0}}, 1'b1};
  assign r_dec  = r_rd - {{RANK_ID_BITS{1'b0}}, 1'b1};
  assign c_dec  = c_rd - {{CASE_ID_BITS{1'b0}}, 1'b1};
  assign t_id   = t_seen ? t_dec[TRICK_ID_BITS-1:0] : next_t_q[TRICK_ID_BITS-1:0];
  assign r_id   = r_seen ? r_dec[RANK_ID_BITS-1:0] : next_r_q[RANK_ID_BITS-1:0];
  assign c_id   = c_seen ? c_dec[CASE_ID_BITS-1:0] : next_c_q[CASE_ID_BITS-1:0];
  assign first_ok = (t_seen | ~next_t_q[TRICK_ID_BITS]) &
                    (r_seen | ~next_r_q[RANK_ID_BITS]) &
                    (c_seen | ~next_c_q[CASE_ID_BITS]);
  assign rck = {r_id, c_id};

  // rankcase lookup
  assign rc_seen = |rc_rd;
  assign rc_dec  = rc_rd - {{RC_ID_BITS{1'b0}}, 1'b1};
  assign rc_id   = rc_seen ? rc_dec[RC_ID_BITS-1:0] : next_rc_q[RC_ID_BITS-1:0];
  assign rc_ok   = rc_seen | ~next_rc_q[RC_ID_BITS];
  assign ok_all  = ok1_q & rc_ok;
  assign cat     = {rc_id, tid_q};

  // table updates: clearing writes during the sweep, transaction writes only without overflow
  assign t_inc  = cmd_i.commit & ok_all & tnew_q;
  assign r_inc  = cmd_i.commit & ok_all & rnew_q;
  assign c_inc  = cmd_i.commit & ok_all & cnew_q;
  assign rc_inc = cmd_i.commit & ok_all & ~rc_seen;

  assign t_we  = cmd_i.sweep | t_inc;
  assign r_we  = cmd_i.sweep | r_inc;
  assign c_we  = cmd_i.sweep | c_inc;
  assign rc_we = cmd_i.sweep | rc_inc;

  assign t_wa  = cmd_i.sweep ? sweep_cnt_q[TRICK_KEY_BITS-1:0] : tk_q;
  assign r_wa  = cmd_i.sweep ? sweep_cnt_q[RANK_KEY_BITS-1:0] : rk_q;
  assign c_wa  = cmd_i.sweep ? sweep_cnt_q[CASE_KEY_BITS-1:0] : ck_q;
  assign rc_wa = cmd_i.sweep ? sweep_cnt_q[RC_KEY_BITS-1:0] : rck_q;

  assign t_wd  = cmd_i.sweep ? '0 : ({1'b0, tid_q} + {{TRICK_ID_BITS{1'b0}}, 1'b1});
  assign r_wd  = cmd_i.sweep ? '0 : ({1'b0, rid_q} + {{RANK_ID_BITS{1'b0}}, 1'b1});
  assign c_wd  = cmd_i.sweep ? '0 : ({1'b0, cid_q} + {{CASE_ID_BITS{1'b0}}, 1'b1});
  assign rc_wd = cmd_i.sweep ? '0 : ({1'b0, rc_id} + {{RC_ID_BITS{1'b0}}, 1'b1});

  assign next_t_d  = next_t_q + {{TRICK_ID_BITS{1'b0}}, 1'b1};
  assign next_r_d  = next_r_q + {{RANK_ID_BITS{1'b0}}, 1'b1};
  assign next_c_d  = next_c_q + {{CASE_ID_BITS{1'b0}}, 1'b1};
  assign next_rc_d = next_rc_q + {{RC_ID_BITS{1'b0}}, 1'b1};

  ckc_ram #(.AddrBits(TRICK_KEY_BITS), .DataBits(TRICK_ID_BITS + 1)) u_trick_ram (
    .clk_i    (clk_i),
    .rd_en_i  (cmd_i.accept),
    .rd_addr_i(trick_key_i),
    .rd_data_o(t_rd),
    .wr_en_i  (t_we),
    .wr_addr_i(t_wa),
    .wr_data_i(t_wd)
  );

  ckc_ram #(.AddrBits(RANK_KEY_BITS), .DataBits(RANK_ID_BITS + 1)) u_rank_ram (
    .clk_i    (clk_i),
    .rd_en_i  (cmd_i.accept),
    .rd_addr_i(rank_key_i),
    .rd_data_o(r_rd),
    .wr_en_i  (r_we),
    .wr_addr_i(r_wa),
    .wr_data_i(r_wd)
  );

  ckc_ram #(.AddrBits(CASE_KEY_BITS), .DataBits(CASE_ID_BITS + 1)) u_case_ram (
    .clk_i    (clk_i),
    .rd_en_i  (cmd_i.accept),
    .rd_addr_i(case_key_i),
    .rd_data_o(c_rd),
    .wr_en_i  (c_we),
    .wr_addr_i(c_wa),
    .wr_data_i(c_wd)
  );

  ckc_ram #(.AddrBits(RC_KEY_BITS), .DataBits(RC_ID_BITS + 1)) u_rankcase_ram (
    .clk_i    (clk_i),
    .rd_en_i  (cmd_i.look),
    .rd_addr_i(rck),
    .rd_data_o(rc_rd),
    .wr_en_i  (rc_we),
    .wr_addr_i(rc_wa),
    .wr_data_i(rc_wd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_cnt_q <= '0;
      next_t_q    <= '0;
      next_r_q    <= '0;
      next_c_q    <= '0;
      next_rc_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.sweep) begin
        sweep_cnt_q <= sweep_cnt_d;
      end
      if (t_inc) begin
        next_t_q <= next_t_d;
      end
      if (r_inc) begin
        next_r_q <= next_r_d;
      end
      if (c_inc) begin
        next_c_q <= next_c_d;
      end
      if (rc_inc) begin
        next_rc_q <= next_rc_d;
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      tk_q <= trick_key_i;
      rk_q <= rank_key_i;
      ck_q <= case_key_i;
    end
    if (cmd_i.look) begin
      tid_q  <= t_id;
      rid_q  <= r_id;
      cid_q  <= c_id;
      tnew_q <= ~t_seen;
      rnew_q <= ~r_seen;
      cnew_q <= ~c_seen;
      ok1_q  <= first_ok;
      rck_q  <= rck;
    end
    if (cmd_i.commit) begin
      compact_q  <= ok_all ? COMPACT_BITS'(cat) : '0;
      overflow_q <= ~ok_all;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign compact_key_o = compact_q;
  assign overflow_o    = overflow_q;

endmodule

/* design/cascaded_key_compactor.sv */
// Flow: an accepted transaction takes the raw-key table reads, then the dependent
// rankcase table read, then the commit, which waits while the output is not taken;
// a new transaction is not accepted until the last one has been committed.
// Reset: counters clear at once; a clearing pass then zeroes all tables, during
// which in_ready_o stays low.
// ----------------------------------------------------------------------------
// cascaded_key_compactor
// Assigns dense ids to trick, rank and case keys in first-seen order and
// compacts the joined rank/case id, returning the packed key and an overflow
// flag.
// ----------------------------------------------------------------------------
`include "cascaded_key_compactor_macros.svh"

module cascaded_key_compactor import ckc_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [TRICK_KEY_BITS-1:0] trick_key_i,
  input  logic [RANK_KEY_BITS-1:0]  rank_key_i,
  input  logic [CASE_KEY_BITS-1:0]  case_key_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [COMPACT_BITS-1:0]   compact_key_o,
  output logic                      overflow_o
);

  ckc_cmd_t    cmd;
  ckc_status_t status;

  ckc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  ckc_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .trick_key_i  (trick_key_i),
    .rank_key_i   (rank_key_i),
    .case_key_i   (case_key_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .compact_key_o(compact_key_o),
    .overflow_o   (overflow_o)
  );

  `CKC_ASSERT_NOW(a_overflow_zero, out_valid_o && overflow_o, compact_key_o == '0, "nonzero key")
  `CKC_ASSERT_NEXT(a_one_in_flight, in_valid_i && in_ready_o, !in_ready_o, "two in flight")
  `CKC_ASSERT_NOW(a_commit_slot, in_valid_i && in_ready_o, ##2 (cmd.commit | out_valid_o), "late")

endmodule
